// ===== hw/rtl/tcst_pkg.sv =====
// package: types, constants and codes for the tcp connection sequence tracker
`default_nettype none

package tcst_pkg;

  localparam int unsigned LEN_BITS = 12;
  localparam int unsigned SEQ_W    = 32;
  localparam int unsigned WIN_W    = 16;
  localparam int unsigned MSS_W    = 12;

  localparam logic [SEQ_W-1:0] LOCAL_ISN_RESET = 32'd1;
  localparam logic [SEQ_W-1:0] PEER_SEQ_RESET  = 32'd0;
  localparam logic [WIN_W-1:0] WINDOW_RESET    = 16'd3072;
  localparam logic [MSS_W-1:0] MSS_RESET       = 12'd536;

  typedef enum logic [1:0] {
    FUNC_APP_DATA = 2'd0,
    FUNC_SEGMENT  = 2'd1,
    FUNC_CLOSE    = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    CFG_LOCAL_ISN   = 2'd0,
    CFG_PEER_SEQ    = 2'd1,
    CFG_WINDOW_SIZE = 2'd2,
    CFG_MAX_SEGMENT = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_ESTABLISHED = 3'd0,
    ST_FIN_WAIT_1  = 3'd1,
    ST_FIN_WAIT_2  = 3'd2,
    ST_CLOSING     = 3'd3,
    ST_CLOSE_WAIT  = 3'd4,
    ST_LAST_ACK    = 3'd5,
    ST_CLOSED      = 3'd6
  } conn_state_e;

  typedef struct packed {
    logic [1:0]          func;
    logic [LEN_BITS-1:0] app_available;
    logic                seg_ack_flag;
    logic                seg_fin_flag;
    logic [SEQ_W-1:0]    seg_seq;
    logic [SEQ_W-1:0]    seg_ack;
    logic [LEN_BITS-1:0] seg_payload_len;
  } in_item_t;

  typedef struct packed {
    logic [SEQ_W-1:0]    pkt_seq;
    logic [SEQ_W-1:0]    pkt_ack;
    logic                pkt_ack_flag;
    logic                pkt_fin_flag;
    logic [LEN_BITS-1:0] send_len;
    logic [LEN_BITS-1:0] deliver_offset;
    logic [LEN_BITS-1:0] deliver_len;
    logic                fin_to_app;
    logic [2:0]          conn_state;
    logic                closed_done;
  } out_item_t;

  typedef struct packed {
    logic             we;
    logic [1:0]       index;
    logic [SEQ_W-1:0] data;
  } cfg_wr_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tcst_core.sv =====
// connection state registers and the per-event update and header logic
`default_nettype none

module tcst_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tcst_pkg::cfg_wr_t   cfg_i,
  input  logic                item_valid_i,
  input  tcst_pkg::in_item_t  item_i,
  output logic                res_valid_o,
  output tcst_pkg::out_item_t res_o
);
  import tcst_pkg::*;

  logic [WIN_W-1:0]    window_q;
  logic [MSS_W-1:0]    mss_q;
  conn_state_e         state_q, state_d, state_ack;
  logic [SEQ_W-1:0]    nss_q, nss_d;
  logic [SEQ_W-1:0]    las_q, las_d;
  logic [SEQ_W-1:0]    nes_q, nes_d;
  logic [SEQ_W-1:0]    fin_seq_q, fin_seq_d;
  logic                finished_q, finished_d;

  logic                process;
  logic [SEQ_W-1:0]    flight;
  logic                room;
  logic [WIN_W-1:0]    room_amt;
  logic [LEN_BITS-1:0] take_mss;
  logic [LEN_BITS-1:0] take;
  logic [SEQ_W-1:0]    diff;
  logic [LEN_BITS-1:0] doff;
  logic [LEN_BITS-1:0] dlen;
  logic                fin_acked;

  assign process = item_valid_i & ~finished_q;

  // send window
  assign flight   = nss_q - las_q;
  assign room     = flight < SEQ_W'(window_q);
  assign room_amt = window_q - flight[WIN_W-1:0];
  assign take_mss = (room_amt > WIN_W'(mss_q)) ? LEN_BITS'(mss_q) : LEN_BITS'(room_amt);
  assign take     = (take_mss > item_i.app_available) ? item_i.app_available : take_mss;

  // receive trimming
  assign diff = nes_q - item_i.seg_seq;
  always_comb begin
    doff = '0;
    dlen = '0;
    if (item_i.seg_payload_len != '0) begin
      if (item_i.seg_seq == nes_q) begin
        dlen = item_i.seg_payload_len;
      end else if (item_i.seg_seq < nes_q && diff < SEQ_W'(item_i.seg_payload_len)) begin
        doff = diff[LEN_BITS-1:0];
        dlen = item_i.seg_payload_len - diff[LEN_BITS-1:0];
      end
    end
  end

  assign fin_acked = item_i.seg_ack_flag && (item_i.seg_ack == fin_seq_q + 32'd1);

  // next state
  always_comb begin
    state_d    = state_q;
    state_ack  = state_q;
    nss_d      = nss_q;
    las_d      = las_q;
    nes_d      = nes_q;
    fin_seq_d  = fin_seq_q;
    finished_d = finished_q;
    if (process) begin
      case (func_e'(item_i.func))
        FUNC_APP_DATA: begin
          if (room) begin
            nss_d = nss_q + SEQ_W'(take);
          end
        end
        FUNC_SEGMENT: begin
          if (item_i.seg_ack_flag) begin
            las_d = item_i.seg_ack;
          end
          if (fin_acked) begin
            case (state_q)
              ST_FIN_WAIT_1: state_ack = ST_FIN_WAIT_2;
              ST_LAST_ACK, ST_CLOSING: begin
                state_ack  = ST_CLOSED;
                finished_d = 1'b1;
              end
              default: state_ack = state_q;
            endcase
          end
          state_d = state_ack;
          nes_d   = nes_q + SEQ_W'(dlen) + SEQ_W'(item_i.seg_fin_flag);
          if (item_i.seg_fin_flag) begin
            case (state_ack)
              ST_ESTABLISHED: state_d = ST_CLOSE_WAIT;
              ST_FIN_WAIT_1:  state_d = ST_CLOSING;
              ST_FIN_WAIT_2: begin
                state_d    = ST_CLOSED;
                finished_d = 1'b1;
              end
              default: state_d = state_ack;
            endcase
          end
        end
        FUNC_CLOSE: begin
          fin_seq_d = nss_q;
          nss_d     = nss_q + 32'd1;
          case (state_q)
            ST_ESTABLISHED: state_d = ST_FIN_WAIT_1;
            ST_CLOSE_WAIT:  state_d = ST_LAST_ACK;
            default:        state_d = state_q;
          endcase
        end
        default: state_d = state_q;
      endcase
    end
  end

  // result header
  always_comb begin
    res_valid_o          = 1'b0;
    res_o.pkt_seq        = nss_q;
    res_o.pkt_ack        = nes_d;
    res_o.pkt_ack_flag   = 1'b1;
    res_o.pkt_fin_flag   = 1'b0;
    res_o.send_len       = '0;
    res_o.deliver_offset = '0;
    res_o.deliver_len    = '0;
    res_o.fin_to_app     = 1'b0;
    res_o.conn_state     = state_d;
    res_o.closed_done    = finished_d;
    case (func_e'(item_i.func))
      FUNC_APP_DATA: begin
        res_valid_o    = process && room && (take != '0);
        res_o.send_len = take;
      end
      FUNC_SEGMENT: begin
        res_valid_o          = process;
        res_o.deliver_offset = doff;
        res_o.deliver_len    = dlen;
        res_o.fin_to_app     = item_i.seg_fin_flag;
      end
      FUNC_CLOSE: begin
        res_valid_o        = process;
        res_o.pkt_fin_flag = 1'b1;
      end
      default: res_valid_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q   <= WINDOW_RESET;
      mss_q      <= MSS_RESET;
      state_q    <= ST_ESTABLISHED;
      nss_q      <= LOCAL_ISN_RESET + 32'd1;
      las_q      <= LOCAL_ISN_RESET + 32'd1;
      nes_q      <= PEER_SEQ_RESET;
      fin_seq_q  <= '0;
      finished_q <= 1'b0;
    end else if (cfg_i.we) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_LOCAL_ISN: begin
          nss_q <= cfg_i.data + 32'd1;
          las_q <= cfg_i.data + 32'd1;
        end
        CFG_PEER_SEQ:    nes_q    <= cfg_i.data;
        CFG_WINDOW_SIZE: window_q <= cfg_i.data[WIN_W-1:0];
        CFG_MAX_SEGMENT: mss_q    <= cfg_i.data[MSS_W-1:0];
        default:         window_q <= window_q;
      endcase
    end else begin
      state_q    <= state_d;
      nss_q      <= nss_d;
      las_q      <= las_d;
      nes_q      <= nes_d;
      fin_seq_q  <= fin_seq_d;
      finished_q <= finished_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tcp_connection_sequence_tracker.sv =====
// top level: input register, connection core and output register
`default_nettype none

// Tracks one established TCP connection, one event per transfer: app data
// (emits a data header sized by window, max segment and available bytes),
// segment arrival (ack, in-order or trimmed delivery, peer fin) and close
// (emits a fin header). An item is accepted every cycle when the output side
// keeps up; an accepted item passes the input register, the core and the
// output register. Events that produce no header (no window room, zero
// bytes, func 3, or any event after the connection has closed) only pass
// through the input register. The update loop on the core's sequence
// registers sets the rate. Configuration writes are always ready and load
// the sequence pointers directly; write them only while the block is idle.
module tcp_connection_sequence_tracker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  tcst_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output tcst_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);
  import tcst_pkg::*;

  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q;
  logic      out_take;
  logic      res_valid;
  out_item_t res;
  cfg_wr_t   cfg_wr;

  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.we    = cfg_valid_i;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  assign out_take   = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = in_valid_q & ~out_take;

  tcst_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_wr),
    .item_valid_i (in_valid_q & out_take),
    .item_i       (in_item_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  assign out_valid_d = out_take ? res_valid : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_item_i;
    end
    if (out_take && res_valid) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

// ===== hw/rtl/tcst_checker.sv =====
// port-level checks for the tcp connection sequence tracker
`default_nettype none

module tcst_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input tcst_pkg::out_item_t out_item_o
);
  import tcst_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  a_closed_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.conn_state == ST_CLOSED) |-> out_item_o.closed_done)
    else $error("closed state without closed_done");

  a_fin_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.pkt_fin_flag |->
      (out_item_o.send_len == '0) && (out_item_o.deliver_len == '0) &&
      !out_item_o.fin_to_app)
    else $error("fin header carries data");

  a_seq_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_item_o.pkt_fin_flag ##1
      out_valid_o && out_item_o.pkt_fin_flag |->
      out_item_o.pkt_seq == $past(out_item_o.pkt_seq) + 32'd1)
    else $error("fin sequence did not advance");

endmodule

bind tcp_connection_sequence_tracker tcst_checker u_tcst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
// testbench: predicts and checks every header of the tcp connection sequence tracker
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcst_pkg::*;

  localparam logic [1:0]  FUNC_IGNORED    = 2'd3;
  localparam int unsigned WATCHDOG_LIMIT  = 1000;
  localparam int unsigned ITEMS_PER_PHASE = 280;
  localparam int unsigned LINGER_ITEMS    = 140;
  localparam int unsigned DRAIN_CYCLES    = 6;

  typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_mode_e;
  typedef enum {VIA_FIN_WAIT_2, VIA_CLOSING, VIA_LAST_ACK} teardown_e;

  class tcp_header_scoreboard;
    logic [31:0] snd_nxt, snd_una, rcv_nxt, fin_seq;
    logic [15:0] win;
    logic [11:0] mss;
    conn_state_e state;
    logic        done;
    out_item_t   expected_hdrs[$];
    int unsigned n_events, n_checked, n_errors;

    function new();
      win       = WINDOW_RESET;
      mss       = MSS_RESET;
      snd_nxt   = LOCAL_ISN_RESET + 32'd1;
      snd_una   = LOCAL_ISN_RESET + 32'd1;
      rcv_nxt   = PEER_SEQ_RESET;
      fin_seq   = '0;
      state     = ST_ESTABLISHED;
      done      = 1'b0;
      n_events  = 0;
      n_checked = 0;
      n_errors  = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [31:0] d);
      case (idx)
        CFG_LOCAL_ISN: begin
          snd_nxt = d + 32'd1;
          snd_una = d + 32'd1;
        end
        CFG_PEER_SEQ:    rcv_nxt = d;
        CFG_WINDOW_SIZE: win = d[15:0];
        CFG_MAX_SEGMENT: mss = d[11:0];
      endcase
    endfunction

    function int unsigned pending();
      return expected_hdrs.size();
    endfunction

    function void note_event(in_item_t ev);
      out_item_t   hdr;
      logic [31:0] flight, take, diff, doff, dlen;
      hdr = '0;
      if (done || ev.func == FUNC_IGNORED) return;
      n_events++;
      hdr.pkt_ack_flag = 1'b1;
      hdr.pkt_seq = snd_nxt;
      case (ev.func)
        FUNC_APP_DATA: begin
          flight = snd_nxt - snd_una;
          if (flight >= 32'(win)) return;
          take = 32'(win) - flight;
          if (take > 32'(mss)) take = 32'(mss);
          if (take > 32'(ev.app_available)) take = 32'(ev.app_available);
          if (take == 32'd0) return;
          hdr.send_len = take[11:0];
          snd_nxt += take;
        end
        FUNC_SEGMENT: begin
          doff = '0;
          dlen = '0;
          if (ev.seg_ack_flag) begin
            snd_una = ev.seg_ack;
            if (ev.seg_ack == fin_seq + 32'd1) begin
              if (state == ST_FIN_WAIT_1) begin
                state = ST_FIN_WAIT_2;
              end else if (state == ST_LAST_ACK || state == ST_CLOSING) begin
                state = ST_CLOSED;
                done  = 1'b1;
              end
            end
          end
          if (ev.seg_payload_len != '0) begin
            if (ev.seg_seq == rcv_nxt) begin
              dlen = 32'(ev.seg_payload_len);
            end else if (ev.seg_seq < rcv_nxt) begin
              diff = rcv_nxt - ev.seg_seq;
              if (diff < 32'(ev.seg_payload_len)) begin
                doff = diff;
                dlen = 32'(ev.seg_payload_len) - diff;
              end
            end
            rcv_nxt += dlen;
          end
          if (ev.seg_fin_flag) begin
            rcv_nxt += 32'd1;
            case (state)
              ST_ESTABLISHED: state = ST_CLOSE_WAIT;
              ST_FIN_WAIT_1:  state = ST_CLOSING;
              ST_FIN_WAIT_2: begin
                state = ST_CLOSED;
                done  = 1'b1;
              end
              default: ;
            endcase
          end
          hdr.deliver_offset = doff[11:0];
          hdr.deliver_len    = dlen[11:0];
          hdr.fin_to_app     = ev.seg_fin_flag;
        end
        FUNC_CLOSE: begin
          fin_seq = snd_nxt;
          if (state == ST_ESTABLISHED) state = ST_FIN_WAIT_1;
          else if (state == ST_CLOSE_WAIT) state = ST_LAST_ACK;
          hdr.pkt_fin_flag = 1'b1;
          snd_nxt += 32'd1;
        end
        default: ;
      endcase
      hdr.pkt_ack     = rcv_nxt;
      hdr.conn_state  = state;
      hdr.closed_done = done;
      expected_hdrs.push_back(hdr);
    endfunction

    function void cmp(string name, logic [31:0] exp_v, logic [31:0] got_v);
      if (got_v !== exp_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, got_v);
        n_errors++;
      end
    endfunction

    function void check_header(out_item_t got);
      out_item_t want;
      if (expected_hdrs.size() == 0) begin
        $error("header with pkt_seq %0h arrived with none expected", got.pkt_seq);
        n_errors++;
        return;
      end
      want = expected_hdrs.pop_front();
      n_checked++;
      cmp("pkt_seq", want.pkt_seq, got.pkt_seq);
      cmp("pkt_ack", want.pkt_ack, got.pkt_ack);
      cmp("pkt_ack_flag", 32'(want.pkt_ack_flag), 32'(got.pkt_ack_flag));
      cmp("pkt_fin_flag", 32'(want.pkt_fin_flag), 32'(got.pkt_fin_flag));
      cmp("send_len", 32'(want.send_len), 32'(got.send_len));
      cmp("deliver_offset", 32'(want.deliver_offset), 32'(got.deliver_offset));
      cmp("deliver_len", 32'(want.deliver_len), 32'(got.deliver_len));
      cmp("fin_to_app", 32'(want.fin_to_app), 32'(got.fin_to_app));
      cmp("conn_state", 32'(want.conn_state), 32'(got.conn_state));
      cmp("closed_done", 32'(want.closed_done), 32'(got.closed_done));
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  in_item_t    in_item_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_item_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i  = '0;

  tcp_header_scoreboard sb = new();
  int unsigned burst_left  = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_left  = 0;
  int unsigned cyc         = 0;
  stall_mode_e stall_mode  = STALL_NONE;

  tcp_connection_sequence_tracker dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 2));
      stall_left <= $urandom_range(20, 150);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:   out_stall_i <= 1'b0;
      STALL_RANDOM: out_stall_i <= ($urandom_range(0, 3) == 0);
      default:      out_stall_i <= (cyc % 8 < 5);
    endcase
  end

  // handshakes sampled mid-cycle, where every signal has settled
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_header(out_item_o);
      if (in_valid_i && !in_stall_o) sb.note_event(in_item_i);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic in_item_t rand_item();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return raw[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t app_ev(logic [11:0] avail);
    in_item_t ev;
    ev = rand_item();
    ev.func = FUNC_APP_DATA;
    ev.app_available = avail;
    return ev;
  endfunction

  function automatic in_item_t seg_ev(logic ackf, logic finf, logic [31:0] seq,
                                      logic [31:0] ack, logic [11:0] plen);
    in_item_t ev;
    ev = rand_item();
    ev.func = FUNC_SEGMENT;
    ev.seg_ack_flag = ackf;
    ev.seg_fin_flag = finf;
    ev.seg_seq = seq;
    ev.seg_ack = ack;
    ev.seg_payload_len = plen;
    return ev;
  endfunction

  function automatic in_item_t close_ev();
    in_item_t ev;
    ev = rand_item();
    ev.func = FUNC_CLOSE;
    return ev;
  endfunction

  // mostly plausible traffic around the current pointers; state moves stay directed
  function automatic in_item_t rand_event();
    in_item_t    ev;
    logic [31:0] flight, plen;
    logic        fin_ok, close_ok, guard;
    int unsigned pick, r;
    fin_ok   = sb.state inside {ST_CLOSE_WAIT, ST_CLOSING, ST_LAST_ACK, ST_CLOSED};
    close_ok = sb.state inside {ST_FIN_WAIT_1, ST_FIN_WAIT_2, ST_CLOSING, ST_LAST_ACK,
                                ST_CLOSED};
    guard    = sb.state inside {ST_FIN_WAIT_1, ST_CLOSING, ST_LAST_ACK};
    ev = rand_item();
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      ev.func = FUNC_APP_DATA;
      r = $urandom_range(0, 9);
      if (r == 0) ev.app_available = '0;
      else if (r == 1) ev.app_available = '1;
      else if (r < 6) ev.app_available = 12'($urandom_range(1, 64));
    end else if (pick < 85) begin
      ev.func = FUNC_SEGMENT;
      ev.seg_ack_flag = ($urandom_range(0, 9) != 0);
      ev.seg_fin_flag = ($urandom_range(0, 9) == 0);
      flight = sb.snd_nxt - sb.snd_una;
      r = $urandom_range(0, 9);
      if (flight > 32'hFFFF || r < 4) ev.seg_ack = sb.snd_nxt;
      else if (r < 8) ev.seg_ack = sb.snd_una + $urandom_range(0, flight);
      else if (r < 9) ev.seg_ack = sb.snd_nxt + $urandom_range(1, 300);
      r = $urandom_range(0, 9);
      if (r < 2) ev.seg_payload_len = '0;
      else if (r < 7) ev.seg_payload_len = 12'($urandom_range(1, 600));
      else if (r < 8) ev.seg_payload_len = '1;
      plen = 32'(ev.seg_payload_len);
      r = $urandom_range(0, 9);
      if (r < 5) ev.seg_seq = sb.rcv_nxt;
      else if (r < 7) ev.seg_seq = sb.rcv_nxt - $urandom_range(1, plen);
      else if (r < 8) ev.seg_seq = sb.rcv_nxt - $urandom_range(plen, plen + 500);
      else if (r < 9) ev.seg_seq = sb.rcv_nxt + $urandom_range(1, 5000);
    end else if (pick < 92) begin
      ev.func = FUNC_CLOSE;
    end
    if (ev.func == FUNC_SEGMENT && !fin_ok) ev.seg_fin_flag = 1'b0;
    if (ev.func == FUNC_SEGMENT && guard && ev.seg_ack == sb.fin_seq + 32'd1)
      ev.seg_ack_flag = 1'b0;
    if (ev.func == FUNC_CLOSE && !close_ok) ev.func = FUNC_IGNORED;
    return ev;
  endfunction

  task automatic send_event(input in_item_t ev);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_item_i  <= ev;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic run_traffic(input int unsigned n);
    in_item_t    ev;
    int unsigned cnt;
    cnt = 0;
    while (cnt < n) begin
      ev = rand_event();
      if (ev.func != FUNC_IGNORED) cnt++;
      send_event(ev);
    end
  endtask

  // events that produce no header may still be in flight once no header is pending
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_conn(input logic [31:0] isn, peer, win, mss);
    logic [31:0] vals [4];
    cfg_idx_e    idx;
    vals = '{isn, peer, win, mss};
    idx = CFG_LOCAL_ISN;
    cfg_valid_i <= 1'b1;
    repeat (4) begin
      cfg_index_i <= idx;
      cfg_data_i  <= vals[idx];
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.write_reg(idx, vals[idx]);
      idx = idx.next();
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    teardown_e route;
    int        phase;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: zero take, window filling up, delivery corner cases
    send_event(app_ev(12'd0));
    send_event(app_ev(12'd4095));
    send_event(app_ev(12'd1));
    repeat (6) send_event(app_ev(12'd4095));
    send_event(seg_ev(1'b1, 1'b0, sb.rcv_nxt, sb.snd_nxt, 12'd0));
    send_event(seg_ev(1'b1, 1'b0, sb.rcv_nxt, sb.snd_nxt, 12'd4095));
    send_event(seg_ev(1'b0, 1'b0, sb.rcv_nxt - 32'd100, 32'd0, 12'd300));
    send_event(seg_ev(1'b0, 1'b0, sb.rcv_nxt - 32'd300, 32'd0, 12'd300));
    send_event(seg_ev(1'b0, 1'b0, sb.rcv_nxt + 32'd1, 32'd0, 12'd10));
    send_event(seg_ev(1'b0, 1'b0, '1, '1, 12'd1));
    send_event(seg_ev(1'b1, 1'b0, 32'd0, sb.snd_nxt + 32'd100, 12'd0));
    send_event(app_ev(12'd4095));
    send_event(seg_ev(1'b1, 1'b0, sb.rcv_nxt, sb.snd_nxt, 12'd0));
    send_event('1);
    send_event(app_ev(12'd2048));
    run_traffic(ITEMS_PER_PHASE);

    for (phase = 1; phase <= 5; phase++) begin
      wait_idle();
      case (phase)
        1: program_conn(32'hFFFF_F000, 32'hFFFF_FF00, 32'd65535, 32'd4095);
        2: program_conn(32'h0, 32'h0, 32'd1, 32'd1);
        3: program_conn('1, '1, $urandom_range(1, 4000), 32'd4095);
        default: program_conn($urandom, $urandom, $urandom_range(1, 65535),
                              $urandom_range(1, 4095));
      endcase
      run_traffic(phase == 5 ? ITEMS_PER_PHASE / 2 : ITEMS_PER_PHASE);
    end

    route = teardown_e'($urandom_range(0, 2));
    case (route)
      VIA_FIN_WAIT_2: begin
        send_event(close_ev());
        run_traffic(LINGER_ITEMS);
        send_event(seg_ev(1'b1, 1'b0, sb.rcv_nxt, sb.fin_seq + 32'd1,
                          12'($urandom_range(0, 50))));
        run_traffic(LINGER_ITEMS);
        send_event(seg_ev(1'b1, 1'b1, sb.rcv_nxt, sb.snd_nxt, 12'd0));
      end
      VIA_CLOSING: begin
        send_event(close_ev());
        run_traffic(LINGER_ITEMS);
        send_event(seg_ev(1'b0, 1'b1, sb.rcv_nxt, $urandom, 12'($urandom_range(0, 50))));
        run_traffic(LINGER_ITEMS);
        send_event(seg_ev(1'b1, 1'b0, sb.rcv_nxt, sb.fin_seq + 32'd1, 12'd0));
      end
      default: begin
        send_event(seg_ev(1'b1, 1'b1, sb.rcv_nxt, sb.snd_nxt, 12'd0));
        run_traffic(LINGER_ITEMS);
        send_event(close_ev());
        run_traffic(LINGER_ITEMS);
        send_event(seg_ev(1'b1, 1'b0, sb.rcv_nxt, sb.fin_seq + 32'd1, 12'd0));
      end
    endcase
    repeat (40) send_event(rand_event());
    wait_idle();

    $display("%0d events handled, %0d headers compared across six register settings",
             sb.n_events, sb.n_checked);
    $display("connection torn down %s, final state %s", route.name(), sb.state.name());
    if (sb.n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
